>>> rtl/tlvp_pkg.sv
package tlvp_pkg;

  // Widths and sizes
  localparam int unsigned KEY_PREFIX_BYTES = 16;
  localparam int unsigned PREFIX_W         = 8 * KEY_PREFIX_BYTES;
  localparam int unsigned PREFIX_IDX_W     = $clog2(KEY_PREFIX_BYTES);
  localparam int unsigned BLEN_W           = 24;

  localparam logic [BLEN_W-1:0] BLOCK_LENGTH_RST = 24'd131072;
  localparam logic [7:0]        TYPE_DONE        = 8'h00;
  localparam logic [7:0]        TYPE_RECORD      = 8'h01;
  localparam logic [7:0]        HDR_LEN_BYTES    = 8'd4;
  localparam logic [7:0]        MAC_VALUE_LEN    = 8'd6;
  localparam logic [7:0]        MAC_SHOWN_LEN    = 8'd17;
  localparam logic [7:0]        KEPT_LIMIT       = 8'd128;

  // Byte roles
  localparam logic [1:0] ROLE_HEADER  = 2'd0;
  localparam logic [1:0] ROLE_KEY     = 2'd1;
  localparam logic [1:0] ROLE_VALUE   = 2'd2;
  localparam logic [1:0] ROLE_IGNORED = 2'd3;

  // Key classes
  localparam logic [1:0] CLASS_PLAIN = 2'd0;
  localparam logic [1:0] CLASS_MAC   = 2'd1;
  localparam logic [1:0] CLASS_BIN   = 2'd2;

  // Status codes
  localparam logic [2:0] ST_PARSING  = 3'd0;
  localparam logic [2:0] ST_DONE     = 3'd1;
  localparam logic [2:0] ST_BAD_TYPE = 3'd2;
  localparam logic [2:0] ST_BAD_REC  = 3'd3;
  localparam logic [2:0] ST_BAD_KEY  = 3'd4;
  localparam logic [2:0] ST_BAD_VAL  = 3'd5;
  localparam logic [2:0] ST_TRUNC    = 3'd6;

  // Key names as ASCII bytes, first character in the top byte
  localparam logic [8*8-1:0]  KEY_MAC_PREFIX = 64'h6d61635f61646472;
  localparam logic [8*14-1:0] KEY_LOADER     = 112'h4c4f414445525f56455253494f4e;
  localparam logic [8*8-1:0]  KEY_MAC        = 64'h4d41435f41444452;
  localparam logic [8*13-1:0] KEY_MAC_MOCA   = 104'h4d41435f414444525f4d4f4341;
  localparam logic [8*11-1:0] KEY_MAC_BT     = 88'h4d41435f414444525f4254;
  localparam logic [8*3-1:0]  KEY_GPN        = 24'h47504e;
  localparam logic [8*8-1:0]  KEY_HDCP       = 64'h484443505f4b4559;
  localparam logic [8*8-1:0]  KEY_DTCP       = 64'h445443505f4b4559;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       block_start;
  } in_t;

  typedef struct packed {
    logic [1:0] byte_role;
    logic [7:0] out_byte;
    logic       record_end;
    logic [1:0] key_class;
    logic       record_kept;
    logic [2:0] status;
  } out_t;

  // Classify a finished key from its stored prefix (first key byte on top)
  function automatic logic [1:0] key_class_of(input logic [PREFIX_W-1:0] pre,
                                              input logic [7:0] klen,
                                              input logic [BLEN_W-1:0] vlen);
    logic [1:0] cls;
    cls = CLASS_PLAIN;
    if (vlen == BLEN_W'(MAC_VALUE_LEN) && klen >= 8'd8 &&
        pre[PREFIX_W-1 -: 64] == KEY_MAC_PREFIX) begin
      cls = CLASS_MAC;
    end else if ((klen == 8'd14 && pre[PREFIX_W-1 -: 112] == KEY_LOADER) ||
                 (klen == 8'd8  && pre[PREFIX_W-1 -: 64]  == KEY_MAC) ||
                 (klen == 8'd13 && pre[PREFIX_W-1 -: 104] == KEY_MAC_MOCA) ||
                 (klen == 8'd11 && pre[PREFIX_W-1 -: 88]  == KEY_MAC_BT) ||
                 (klen == 8'd3  && pre[PREFIX_W-1 -: 24]  == KEY_GPN) ||
                 (klen == 8'd8  && pre[PREFIX_W-1 -: 64]  == KEY_HDCP) ||
                 (klen == 8'd8  && pre[PREFIX_W-1 -: 64]  == KEY_DTCP)) begin
      cls = CLASS_BIN;
    end
    return cls;
  endfunction

endpackage

>>> rtl/tlv_record_parser.sv
// Byte-serial parser for blocks of type-length-value records.
// Input channel (in_valid/in_ready/in_data): one request per raw byte, with
// block_start set on byte 0 of each block to restart the parser.
// Result channel (out_valid/out_ready/out_data): exactly one result per input
// byte, in order: byte role, the byte itself, record end with key class and
// kept flag, and a status that is nonzero only on the byte that stops parsing.
// Configuration: cfg_wr_en/cfg_wr_data write the block length in bytes; write
// it only while no request is in flight.
// The result of a byte is registered and is on out_data in the cycle after acceptance.
// Throughput: one byte per cycle while out_ready holds; the phase machine, counters
// and length compares are all combinational between input and result register.
// When the receiver stalls, the result register holds and in_ready follows
// out_ready, so a new byte is taken in the same cycle the held result leaves.
// Reset clears the phase machine, counters and output valid; block length
// returns to 131072. The key prefix bytes are not cleared.
module tlv_record_parser (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  tlvp_pkg::in_t                       in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output tlvp_pkg::out_t                      out_data,
  input  logic                                cfg_wr_en,
  input  logic [tlvp_pkg::BLEN_W-1:0]         cfg_wr_data
);

  typedef enum logic [5:0] {
    PH_TYPE   = 6'b000001,
    PH_RECLEN = 6'b000010,
    PH_KEYLEN = 6'b000100,
    PH_KEY    = 6'b001000,
    PH_VALLEN = 6'b010000,
    PH_VALUE  = 6'b100000
  } phase_t;

  logic [tlvp_pkg::BLEN_W-1:0]   block_length_r;
  logic [tlvp_pkg::BLEN_W-1:0]   pos_r, pos_nxt;
  phase_t                        phase_r, phase_nxt;
  logic [tlvp_pkg::BLEN_W-1:0]   fc_r, fc_nxt;
  logic [tlvp_pkg::BLEN_W-1:0]   ls_r, ls_nxt;
  logic [7:0]                    klen_r, klen_nxt;
  logic [tlvp_pkg::BLEN_W-1:0]   vlen_r, vlen_nxt;
  logic                          stop_r, stop_nxt;
  logic                          out_valid_r;
  tlvp_pkg::out_t                out_r, res;

  logic [7:0]                    key_store_r [tlvp_pkg::KEY_PREFIX_BYTES];
  logic [tlvp_pkg::PREFIX_W-1:0] prefix;

  logic                          in_fire;
  logic [7:0]                    b;
  logic [tlvp_pkg::BLEN_W-1:0]   eff_pos, eff_fc, eff_ls;
  phase_t                        eff_phase;
  logic                          eff_stop;
  logic [tlvp_pkg::BLEN_W:0]     p;
  logic [31:0]                   shifted;
  logic [32:0]                   end_sum;
  logic [tlvp_pkg::BLEN_W+1:0]   key_sum;
  logic [7:0]                    key_idx;
  logic                          key_we;
  logic                          finish;
  logic [tlvp_pkg::BLEN_W-1:0]   fin_vlen;
  logic [1:0]                    fin_class;
  logic [tlvp_pkg::BLEN_W+1:0]   shown;
  logic [tlvp_pkg::BLEN_W+1:0]   kept_sum;

  assign in_fire   = in_valid && in_ready;
  assign in_ready  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign b         = in_data.data_byte;

  // Block start restarts the walk for this byte
  assign eff_stop  = in_data.block_start ? 1'b0 : stop_r;
  assign eff_pos   = in_data.block_start ? '0 : pos_r;
  assign eff_phase = in_data.block_start ? PH_TYPE : phase_r;
  assign eff_fc    = in_data.block_start ? '0 : fc_r;
  assign eff_ls    = in_data.block_start ? '0 : ls_r;

  // Length arithmetic: p counts bytes consumed including this one
  assign p       = {1'b0, eff_pos} + (tlvp_pkg::BLEN_W+1)'(1);
  assign shifted = {eff_ls, b};
  assign end_sum = 33'(p) + {1'b0, shifted};
  assign key_sum = {1'b0, p} + (tlvp_pkg::BLEN_W+2)'(b);
  assign key_idx = klen_r - eff_fc[7:0];

  // Flat view of the stored key prefix, first key byte on top
  always_comb begin
    for (int i = 0; i < tlvp_pkg::KEY_PREFIX_BYTES; i++) begin
      prefix[8*(tlvp_pkg::KEY_PREFIX_BYTES-1-i) +: 8] = key_store_r[i];
    end
  end

  // Record classification at record end; an empty value closes on its length
  assign fin_vlen  = (eff_phase == PH_VALLEN) ? '0 : vlen_r;
  assign fin_class = tlvp_pkg::key_class_of(prefix, klen_r, fin_vlen);
  always_comb begin
    case (fin_class)
      tlvp_pkg::CLASS_MAC: shown = (tlvp_pkg::BLEN_W+2)'(tlvp_pkg::MAC_SHOWN_LEN);
      tlvp_pkg::CLASS_BIN: shown = {1'b0, fin_vlen, 1'b0};
      default:             shown = (tlvp_pkg::BLEN_W+2)'(fin_vlen);
    endcase
  end
  assign kept_sum = shown + (tlvp_pkg::BLEN_W+2)'(klen_r);

  // Phase machine and per-byte result
  always_comb begin
    pos_nxt   = eff_pos;
    phase_nxt = eff_phase;
    fc_nxt    = eff_fc;
    ls_nxt    = eff_ls;
    stop_nxt  = eff_stop;
    klen_nxt  = klen_r;
    vlen_nxt  = vlen_r;
    key_we    = 1'b0;
    finish    = 1'b0;
    res.byte_role   = tlvp_pkg::ROLE_HEADER;
    res.out_byte    = b;
    res.record_end  = 1'b0;
    res.key_class   = tlvp_pkg::CLASS_PLAIN;
    res.record_kept = 1'b0;
    res.status      = tlvp_pkg::ST_PARSING;

    if (eff_stop) begin
      res.byte_role = tlvp_pkg::ROLE_IGNORED;
    end else if (eff_pos >= block_length_r) begin
      // block length lowered below the position reached
      res.status = tlvp_pkg::ST_TRUNC;
      stop_nxt   = 1'b1;
    end else begin
      case (eff_phase)
        PH_TYPE: begin
          if (b == tlvp_pkg::TYPE_DONE) begin
            res.status = tlvp_pkg::ST_DONE;
            stop_nxt   = 1'b1;
          end else if (b != tlvp_pkg::TYPE_RECORD) begin
            res.status = tlvp_pkg::ST_BAD_TYPE;
            stop_nxt   = 1'b1;
          end else begin
            phase_nxt = PH_RECLEN;
            fc_nxt    = tlvp_pkg::BLEN_W'(tlvp_pkg::HDR_LEN_BYTES);
            ls_nxt    = '0;
          end
        end
        PH_RECLEN: begin
          ls_nxt = shifted[tlvp_pkg::BLEN_W-1:0];
          fc_nxt = eff_fc - tlvp_pkg::BLEN_W'(1);
          if (fc_nxt == '0) begin
            if (shifted[31] || shifted[30:0] <= 31'd6 ||
                end_sum >= 33'(block_length_r)) begin
              res.status = tlvp_pkg::ST_BAD_REC;
              stop_nxt   = 1'b1;
            end else begin
              phase_nxt = PH_KEYLEN;
            end
          end
        end
        PH_KEYLEN: begin
          if (b == 8'd0 || key_sum >= (tlvp_pkg::BLEN_W+2)'(block_length_r)) begin
            res.status = tlvp_pkg::ST_BAD_KEY;
            stop_nxt   = 1'b1;
          end else begin
            klen_nxt  = b;
            fc_nxt    = tlvp_pkg::BLEN_W'(b);
            phase_nxt = PH_KEY;
          end
        end
        PH_KEY: begin
          res.byte_role = tlvp_pkg::ROLE_KEY;
          key_we = key_idx < 8'(tlvp_pkg::KEY_PREFIX_BYTES);
          fc_nxt = eff_fc - tlvp_pkg::BLEN_W'(1);
          if (fc_nxt == '0) begin
            phase_nxt = PH_VALLEN;
            fc_nxt    = tlvp_pkg::BLEN_W'(tlvp_pkg::HDR_LEN_BYTES);
            ls_nxt    = '0;
          end
        end
        PH_VALLEN: begin
          ls_nxt = shifted[tlvp_pkg::BLEN_W-1:0];
          fc_nxt = eff_fc - tlvp_pkg::BLEN_W'(1);
          if (fc_nxt == '0) begin
            if (shifted[31] || end_sum >= 33'(block_length_r)) begin
              res.status = tlvp_pkg::ST_BAD_VAL;
              stop_nxt   = 1'b1;
            end else begin
              // fits the block, so well under 2^24
              vlen_nxt = shifted[tlvp_pkg::BLEN_W-1:0];
              if (shifted[tlvp_pkg::BLEN_W-1:0] == '0) begin
                finish    = 1'b1;
                phase_nxt = PH_TYPE;
              end else begin
                fc_nxt    = shifted[tlvp_pkg::BLEN_W-1:0];
                phase_nxt = PH_VALUE;
              end
            end
          end
        end
        PH_VALUE: begin
          res.byte_role = tlvp_pkg::ROLE_VALUE;
          fc_nxt = eff_fc - tlvp_pkg::BLEN_W'(1);
          if (fc_nxt == '0) begin
            finish    = 1'b1;
            phase_nxt = PH_TYPE;
          end
        end
        default: begin
          phase_nxt = PH_TYPE;
        end
      endcase

      if (finish) begin
        res.record_end  = 1'b1;
        res.key_class   = fin_class;
        res.record_kept = kept_sum < (tlvp_pkg::BLEN_W+2)'(tlvp_pkg::KEPT_LIMIT);
      end

      // Advance position; the byte that fills the block ends parsing
      if (!stop_nxt) begin
        pos_nxt = p[tlvp_pkg::BLEN_W-1:0];
        if (p >= {1'b0, block_length_r}) begin
          res.status = tlvp_pkg::ST_TRUNC;
          stop_nxt   = 1'b1;
        end
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_length_r <= tlvp_pkg::BLOCK_LENGTH_RST;
      pos_r          <= '0;
      phase_r        <= PH_TYPE;
      fc_r           <= '0;
      ls_r           <= '0;
      klen_r         <= '0;
      vlen_r         <= '0;
      stop_r         <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        block_length_r <= cfg_wr_data;
      end
      if (in_fire) begin
        pos_r   <= pos_nxt;
        phase_r <= phase_nxt;
        fc_r    <= fc_nxt;
        ls_r    <= ls_nxt;
        klen_r  <= klen_nxt;
        vlen_r  <= vlen_nxt;
        stop_r  <= stop_nxt;
      end
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_r <= res;
    end
  end

  // Key prefix store
  always_ff @(posedge clk) begin
    if (in_fire && key_we) begin
      key_store_r[key_idx[tlvp_pkg::PREFIX_IDX_W-1:0]] <= b;
    end
  end

  // A held result is never overwritten by a new request
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && out_valid_r |-> out_ready)
    else $error("result overwritten while stalled");

  // Ignored bytes carry no status and no record end
  a_ignored_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.byte_role == tlvp_pkg::ROLE_IGNORED |->
      out_r.status == tlvp_pkg::ST_PARSING && !out_r.record_end)
    else $error("ignored byte reports status");

  // A nonzero status leaves the parser stopped
  a_status_stops: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && res.status != tlvp_pkg::ST_PARSING |=> stop_r)
    else $error("parser not stopped after status");

  // Record end only on header or value bytes
  a_end_role: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.record_end |->
      (out_r.byte_role == tlvp_pkg::ROLE_VALUE ||
       out_r.byte_role == tlvp_pkg::ROLE_HEADER))
    else $error("record end on key or ignored byte");

endmodule
